/* rtl/pcxd_pkg.sv */
// ----------------------------------------------------------------------------
// PCX run-length decoder package
// Shared constants, request codes and payload types.
// ----------------------------------------------------------------------------
package pcxd_pkg;

  localparam int MAX_LINE_BYTES_DEF = 1024;
  localparam int MAX_WIDTH_DEF      = 8192;
  localparam int MAX_HEIGHT_DEF     = 4096;
  localparam int PALETTE_DEPTH_DEF  = 256;

  localparam logic [7:0] RUN_MARK = 8'hC0;

  typedef enum logic [1:0] {
    REQ_PAL   = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_START = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_BPL    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] MODE_BIT1  = 2'd0;
  localparam logic [1:0] MODE_PLN4  = 2'd1;
  localparam logic [1:0] MODE_IDX8  = 2'd2;
  localparam logic [1:0] MODE_RGB24 = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_rgb;
  } in_t;

  typedef struct packed {
    logic [23:0] pixel_a;
    logic [23:0] pixel_b;
    logic [23:0] pixel_c;
    logic [23:0] pixel_d;
    logic [23:0] pixel_e;
    logic [23:0] pixel_f;
    logic [23:0] pixel_g;
    logic [23:0] pixel_h;
    logic [3:0]  pixel_count;
    logic [12:0] first_column;
    logic [11:0] out_row;
    logic        last_of_item;
  } out_t;

endpackage

/* rtl/pcxd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pcxd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pcx_rle_palette_decoder_top.sv */
// ----------------------------------------------------------------------------
// PCX run-length palette decoder
// Expands a PCX byte stream into groups of up to eight RGB pixels.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes palette writes, compressed
// bytes and start-of-image requests; one transfer at a time, in_ready is high
// only while no item is in work. Palette writes, start requests and run
// headers are handled without leaving idle. A data byte item ends with a
// closing step after its last decoded byte. Each decoded byte goes through
// plane store read, decode and emit; in the palette modes, lookup steps for
// its pixels come before the emit, all through the single palette read port.
// Bytes that are only stored or fully dropped skip lookup and emit.
// A run byte repeats this per copy. One result is held back so the last one
// of an item can be marked; it leaves after the item's last byte.
// Output channel (out_valid/out_ready/out_data) is a register; while the
// receiver stalls, at most one more result is buffered, then decoding waits.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; the
// user is to write it only while the block is idle; the block does not check.
// Reset restores the register defaults (8-bit mode, 320x200, 320 bytes per
// line) and clears the position state; palette and plane store are not
// cleared.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder_top
  import pcxd_pkg::*;
#(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
  parameter int PALETTE_DEPTH  = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int LAW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_PX, S_LK, S_EMIT, S_END
  } state_t;

  state_t      state_r;
  logic [1:0]  mode_r;
  logic [10:0] bpl_r;
  logic [13:0] width_r;
  logic [12:0] height_r;
  logic        hdr_r;
  logic [5:0]  runl_r;
  logic [10:0] pos_r;
  logic [1:0]  plane_r;
  logic [11:0] line_r;
  logic        fin_r;
  logic [7:0]  byte_r;
  logic [5:0]  rem_r;
  logic [3:0]  k_r;
  logic [3:0]  cnt_r;
  logic [12:0] col_r;
  logic        lk_ok_r;
  logic [23:0] px_r [8];
  logic        hold_v_r;
  out_t        hold_r;
  logic        out_v_r;
  out_t        out_r;

  // effective sizes
  logic [10:0] ebpl;
  logic [16:0] ewid;
  logic [12:0] ehgt;
  logic [2:0]  planes;
  logic        finished;
  logic        last_plane;

  always_comb begin
    ebpl = bpl_r;
    if (bpl_r == 11'd0) ebpl = 11'd1;
    if (32'(bpl_r) > MAX_LINE_BYTES) ebpl = 11'(MAX_LINE_BYTES);
    ewid = (32'(width_r) > MAX_WIDTH) ? 17'(MAX_WIDTH) : 17'(width_r);
    ehgt = (32'(height_r) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : height_r;
    case (mode_r)
      MODE_PLN4:  planes = 3'd4;
      MODE_RGB24: planes = 3'd3;
      default:    planes = 3'd1;
    endcase
    finished   = fin_r || ({1'b0, line_r} >= ehgt);
    last_plane = ({1'b0, plane_r} + 3'd1) >= planes;
  end

  // position after one decoded byte
  logic [10:0] pos_adv;
  logic [1:0]  plane_adv;
  logic [11:0] line_adv;
  logic        fin_adv;

  always_comb begin
    pos_adv   = pos_r + 11'd1;
    plane_adv = plane_r;
    line_adv  = line_r;
    fin_adv   = fin_r;
    if ({1'b0, pos_r} + 12'd1 >= {1'b0, ebpl}) begin
      pos_adv = 11'd0;
      if (({1'b0, plane_r} + 3'd1) >= planes) begin
        plane_adv = 2'd0;
        if ({1'b0, line_r} + 13'd1 >= ehgt) fin_adv = 1'b1;
        else line_adv = line_r + 12'd1;
      end else begin
        plane_adv = plane_r + 2'd1;
      end
    end
  end

  // plane store
  logic           ps_we;
  logic           ps_re;
  logic [LAW-1:0] ps_addr;
  logic [23:0]    ps_rd;
  logic [23:0]    ps_wd;
  logic           pos_ok;

  assign pos_ok  = 32'(pos_r) < MAX_LINE_BYTES;
  assign ps_addr = LAW'(pos_r);
  assign ps_re   = (state_r == S_RD) && pos_ok;

  always_comb begin
    ps_wd = ps_rd;
    case (plane_r)
      2'd0:    ps_wd[7:0]   = byte_r;
      2'd1:    ps_wd[15:8]  = byte_r;
      2'd2:    ps_wd[23:16] = byte_r;
      default: ps_wd        = ps_rd;
    endcase
  end

  logic [23:0] st;
  assign st = pos_ok ? ps_rd : 24'd0;

  assign ps_we = (state_r == S_PX) && !last_plane && pos_ok &&
                 (mode_r == MODE_PLN4 || mode_r == MODE_RGB24) && (plane_r != 2'd3);

  pcxd_ram #(.WIDTH(24), .DEPTH(MAX_LINE_BYTES), .AW(LAW)) u_plane_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_addr),
    .wdata (ps_wd),
    .re    (ps_re),
    .raddr (ps_addr),
    .rdata (ps_rd)
  );

  // palette
  logic           in_acc;
  logic           pal_we;
  logic           pal_re;
  logic [7:0]     pidx;
  logic [2:0]     bsel;
  logic [23:0]    pal_rd;

  assign in_acc = in_valid && in_ready;
  assign pal_we = in_acc && (in_data.req_type == REQ_PAL) &&
                  (32'(in_data.palette_index) < PALETTE_DEPTH);
  assign pal_re = (state_r == S_LK) && (k_r < cnt_r);
  assign bsel   = 3'd7 - k_r[2:0];

  always_comb begin
    case (mode_r)
      MODE_BIT1: pidx = {7'd0, byte_r[bsel]};
      MODE_PLN4: pidx = {4'd0, byte_r[bsel], st[16 + 32'(bsel)],
                         st[8 + 32'(bsel)], st[bsel]};
      default:   pidx = byte_r;
    endcase
  end

  pcxd_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH), .AW(PAW)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (PAW'(in_data.palette_index)),
    .wdata (in_data.palette_rgb),
    .re    (pal_re),
    .raddr (PAW'(pidx)),
    .rdata (pal_rd)
  );

  // decode of the current byte
  logic [16:0] col_full;
  logic [3:0]  ngroup;
  logic [16:0] avail;
  logic [3:0]  cnt_new;

  always_comb begin
    col_full = (mode_r == MODE_BIT1 || mode_r == MODE_PLN4) ?
               {3'd0, pos_r, 3'd0} : {6'd0, pos_r};
    ngroup   = (mode_r == MODE_BIT1 || mode_r == MODE_PLN4) ? 4'd8 : 4'd1;
    avail    = ewid - col_full;
    cnt_new  = (avail > 17'(ngroup)) ? ngroup : avail[3:0];
  end

  out_t        res;
  logic [12:0] row;
  logic        out_free;

  assign row      = ehgt - 13'd1 - {1'b0, line_r};
  assign out_free = !out_v_r || out_ready;

  always_comb begin
    res              = '0;
    res.pixel_a      = px_r[0];
    res.pixel_b      = px_r[1];
    res.pixel_c      = px_r[2];
    res.pixel_d      = px_r[3];
    res.pixel_e      = px_r[4];
    res.pixel_f      = px_r[5];
    res.pixel_g      = px_r[6];
    res.pixel_h      = px_r[7];
    res.pixel_count  = cnt_r;
    res.first_column = col_r;
    res.out_row      = row[11:0];
    res.last_of_item = 1'b0;
  end

  // move the held result into the output register
  logic out_load;
  out_t out_nxt;

  always_comb begin
    out_load = 1'b0;
    out_nxt  = hold_r;
    if (hold_v_r && out_free) begin
      if (state_r == S_EMIT) begin
        out_load = 1'b1;
      end else if (state_r == S_END) begin
        out_load             = 1'b1;
        out_nxt.last_of_item = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= MODE_IDX8;
      bpl_r    <= 11'd320;
      width_r  <= 14'd320;
      height_r <= 13'd200;
      hdr_r    <= 1'b0;
      runl_r   <= 6'd0;
      pos_r    <= 11'd0;
      plane_r  <= 2'd0;
      line_r   <= 12'd0;
      fin_r    <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_r   <= out_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MODE:   mode_r   <= cfg_data[1:0];
          CFG_BPL:    bpl_r    <= cfg_data[10:0];
          CFG_WIDTH:  width_r  <= cfg_data;
          CFG_HEIGHT: height_r <= cfg_data[12:0];
          default:    mode_r   <= mode_r;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            byte_r <= in_data.data_byte;
            case (req_t'(in_data.req_type))
              REQ_START: begin
                hdr_r   <= 1'b0;
                runl_r  <= 6'd0;
                pos_r   <= 11'd0;
                plane_r <= 2'd0;
                line_r  <= 12'd0;
                fin_r   <= 1'b0;
              end
              REQ_DATA: begin
                if (!finished) begin
                  if (hdr_r) begin
                    hdr_r  <= 1'b0;
                    runl_r <= 6'd0;
                    rem_r  <= runl_r;
                    state_r <= S_RD;
                  end else if (in_data.data_byte >= RUN_MARK) begin
                    hdr_r  <= 1'b1;
                    runl_r <= in_data.data_byte[5:0];
                  end else begin
                    rem_r  <= 6'd1;
                    state_r <= S_RD;
                  end
                end
              end
              default: hdr_r <= hdr_r;
            endcase
          end
        end

        S_RD: begin
          if (rem_r == 6'd0 || finished) begin
            state_r <= S_END;
          end else begin
            rem_r   <= rem_r - 6'd1;
            state_r <= S_PX;
          end
        end

        S_PX: begin
          px_r[0] <= (mode_r == MODE_RGB24) ? {st[7:0], st[15:8], byte_r} : 24'd0;
          for (int i = 1; i < 8; i++) px_r[i] <= 24'd0;
          k_r   <= 4'd0;
          cnt_r <= cnt_new;
          col_r <= col_full[12:0];
          if ((!last_plane && (mode_r == MODE_PLN4 || mode_r == MODE_RGB24)) ||
              col_full >= ewid) begin
            // no pixel from this byte
            pos_r   <= pos_adv;
            plane_r <= plane_adv;
            line_r  <= line_adv;
            fin_r   <= fin_adv;
            state_r <= S_RD;
          end else if (mode_r == MODE_RGB24) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_LK;
          end
        end

        S_LK: begin
          lk_ok_r <= 32'(pidx) < PALETTE_DEPTH;
          if (k_r != 4'd0) px_r[k_r[2:0] - 3'd1] <= lk_ok_r ? pal_rd : 24'd0;
          if (k_r == cnt_r) state_r <= S_EMIT;
          else k_r <= k_r + 4'd1;
        end

        S_EMIT: begin
          if (!hold_v_r || out_free) begin
            hold_r   <= res;
            hold_v_r <= 1'b1;
            pos_r    <= pos_adv;
            plane_r  <= plane_adv;
            line_r   <= line_adv;
            fin_r    <= fin_adv;
            state_r  <= S_RD;
          end
        end

        S_END: begin
          if (!hold_v_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            hold_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
